@@ rtl/core/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; used by tcw_engine and text_console_writer.
`default_nettype none

package tcw_pkg;

   localparam int SCREEN_COLUMNS_DEF = 80;
   localparam int SCREEN_ROWS_DEF    = 25;

   localparam int POS_W  = 11;
   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;

   localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0F;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [CELL_W-1:0] cell_word;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/tcw_screen_ram.sv @@
// Screen cell memory: one write port, one registered read port.
// Depends on nothing; instantiated by text_console_writer.
`default_nettype none

module tcw_screen_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] cells_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/tcw_engine.sv @@
// Console sequencer: cursor, put/clear/read handling, scroll copy and blank sweeps.
// Depends on tcw_pkg; drives the ports of tcw_screen_ram.
`default_nettype none

module tcw_engine #(
   parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF,
   parameter int ADDR_W         = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire tcw_pkg::op_type              req_op,
   input  wire logic [tcw_pkg::CHAR_W-1:0]   req_char,
   input  wire logic [tcw_pkg::POS_W-1:0]    req_addr,
   input  wire logic [tcw_pkg::ATTR_W-1:0]   attr,
   output      logic                         res_valid,
   input  wire logic                         res_ready,
   output      tcw_pkg::result_type          res,
   output      logic                         mem_wr_en,
   output      logic [ADDR_W-1:0]            mem_wr_addr,
   output      logic [tcw_pkg::CELL_W-1:0]   mem_wr_data,
   output      logic                         mem_rd_en,
   output      logic [ADDR_W-1:0]            mem_rd_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0]   mem_rd_data
);

   localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int COL_W      = $clog2(SCREEN_COLUMNS);
   localparam int ROW_W      = $clog2(SCREEN_ROWS);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXEC   = 7'b0000010,
      ST_RDWAIT = 7'b0000100,
      ST_SCROLL = 7'b0001000,
      ST_BLANK  = 7'b0010000,
      ST_CLEAR  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [CNT_W-1:0]              scan_ff, scan_in;
   logic                          pend_ff, pend_in;
   logic [ADDR_W-1:0]             pend_addr_ff, pend_addr_in;
   logic [tcw_pkg::CELL_W-1:0]    word_ff, word_in;
   tcw_pkg::op_type               op_ff;
   logic [tcw_pkg::CHAR_W-1:0]    char_ff;
   logic [tcw_pkg::POS_W-1:0]     addr_ff;

   logic [ADDR_W-1:0]             cur_index;
   logic [COL_W:0]                col_inc;
   logic [ROW_W:0]                row_inc;
   logic [tcw_pkg::CELL_W-1:0]    blank_word;
   logic                          col_nonzero;

   assign cur_index   = ADDR_W'(32'(row_ff) * SCREEN_COLUMNS + 32'(col_ff));
   assign col_inc     = (COL_W+1)'(col_ff) + (COL_W+1)'(1);
   assign row_inc     = (ROW_W+1)'(row_ff) + (ROW_W+1)'(1);
   assign blank_word  = {attr, tcw_pkg::CHAR_BLANK};
   assign col_nonzero = (col_ff != '0);

   assign req_ready           = (state_ff == ST_IDLE);
   assign res_valid           = (state_ff == ST_DONE);
   assign res.cursor_position = tcw_pkg::POS_W'(cur_index);
   assign res.cell_word       = word_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_op;
         char_ff <= req_char;
         addr_ff <= req_addr;
      end
      pend_addr_ff <= pend_addr_in;
      word_ff      <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         scan_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      word_in      = word_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cur_index;
      mem_wr_data  = blank_word;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = scan_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            word_in  = '0;
            state_in = ST_DONE;
            unique case (op_ff)
               tcw_pkg::OP_PUT: begin
                  priority if (char_ff == tcw_pkg::CHAR_NEWLINE) begin
                     col_in = '0;
                     row_in = row_inc[ROW_W-1:0];
                  end else if (char_ff == tcw_pkg::CHAR_BACKSPACE) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = cur_index - ADDR_W'(col_nonzero);
                     col_in      = col_ff - COL_W'(col_nonzero);
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = {attr, char_ff};
                     if (col_inc == (COL_W+1)'(SCREEN_COLUMNS)) begin
                        col_in = '0;
                        row_in = row_inc[ROW_W-1:0];
                     end else begin
                        col_in = col_inc[COL_W-1:0];
                     end
                  end
                  if ((char_ff == tcw_pkg::CHAR_NEWLINE
                       || (char_ff != tcw_pkg::CHAR_BACKSPACE
                           && col_inc == (COL_W+1)'(SCREEN_COLUMNS)))
                      && row_inc == (ROW_W+1)'(SCREEN_ROWS)) begin
                     row_in   = ROW_W'(SCREEN_ROWS - 1);
                     scan_in  = CNT_W'(SCREEN_COLUMNS);
                     state_in = ST_SCROLL;
                  end
               end
               tcw_pkg::OP_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  scan_in  = '0;
                  state_in = ST_CLEAR;
               end
               tcw_pkg::OP_READ: begin
                  if (32'(addr_ff) < CELL_COUNT) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ADDR_W'(addr_ff);
                     state_in    = ST_RDWAIT;
                  end
               end
               tcw_pkg::OP_NONE: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_RDWAIT: begin
            word_in  = mem_rd_data;
            state_in = ST_DONE;
         end

         ST_SCROLL: begin
            mem_wr_en   = pend_ff;
            mem_wr_addr = pend_addr_ff;
            mem_wr_data = mem_rd_data;
            if (scan_ff != CNT_W'(CELL_COUNT)) begin
               mem_rd_en    = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ADDR_W'(scan_ff - CNT_W'(SCREEN_COLUMNS));
               scan_in      = scan_ff + CNT_W'(1);
            end else begin
               scan_in  = CNT_W'(CELL_COUNT - SCREEN_COLUMNS);
               state_in = ST_BLANK;
            end
         end

         ST_BLANK, ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = scan_ff[ADDR_W-1:0];
            if (scan_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = ST_DONE;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < SCREEN_COLUMNS) && (32'(row_ff) < SCREEN_ROWS))
      else $error("cursor outside the screen");

   a_scroll_copy_offset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL && mem_wr_en)
      |-> (32'(mem_wr_addr) + SCREEN_COLUMNS == 32'($past(mem_rd_addr))))
      else $error("scroll copy writes the wrong row");

   a_clear_homes_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (col_ff == '0 && row_ff == '0))
      else $error("cursor not homed during clear");

   a_scroll_on_last_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL || state_ff == ST_BLANK)
      |-> (32'(row_ff) == SCREEN_ROWS - 1 && col_ff == '0))
      else $error("scroll without cursor on last row");

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// Text console writer top level: attribute register, result register, cell memory.
// Depends on tcw_pkg, tcw_screen_ram and tcw_engine.
//
//   channel | ports                           | payload
//   --------+---------------------------------+------------------------------------------
//   request | req_tvalid/req_tready           | tuser: op; tdata: char_code, cell_address
//   result  | rsp_tvalid/rsp_tready           | tdata: cursor_position, cell_word
//   config  | csr_valid/csr_ready             | csr_data: text_attribute
//
// During a scroll the single write port of the cell memory copies one cell per cycle
// and then blanks the bottom row.
// Reset clears the cursor and sets the attribute to 0x0F; cell contents stay
// undefined until written. A new request is taken while a result still waits
// in the result register; the following one waits until that result is taken.
`default_nettype none

module text_console_writer #(
   parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] char_code, [18:8] cell_address, rest zero
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [10:0] cursor_position, [26:11] cell_word, rest zero
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_data
);

   localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   logic [tcw_pkg::ATTR_W-1:0]  attr_ff;
   logic                        rsp_valid_ff;
   tcw_pkg::result_type         rsp_data_ff;

   logic                        res_valid;
   logic                        res_ready;
   tcw_pkg::result_type         res;

   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   logic [tcw_pkg::CELL_W-1:0]  mem_wr_data;
   logic                        mem_rd_en;
   logic [ADDR_W-1:0]           mem_rd_addr;
   logic [tcw_pkg::CELL_W-1:0]  mem_rd_data;

   assign csr_ready = 1'b1;
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::ATTR_RESET;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.cell_word, rsp_data_ff.cursor_position};

   tcw_engine #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .ADDR_W         (ADDR_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (tcw_pkg::op_type'(req_tuser)),
      .req_char    (req_tdata[7:0]),
      .req_addr    (req_tdata[18:8]),
      .attr        (attr_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   tcw_screen_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W),
      .DATA_W (tcw_pkg::CELL_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

@@ sim/tb_text_console_writer.sv @@
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer: directed and random console traffic,
// checked against a screen and cursor model kept in the bench. Depends on tcw_pkg and text_console_writer.
module tb_text_console_writer;

   localparam int COLS          = tcw_pkg::SCREEN_COLUMNS_DEF;
   localparam int ROWS          = tcw_pkg::SCREEN_ROWS_DEF;
   localparam int CELLS         = COLS * ROWS;
   localparam int SETTLE_CYCLES = 2 * CELLS + 100;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] char_code, [18:8] cell_address, rest zero
   logic [1:0]  req_tuser  = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [10:0] cursor_position, [26:11] cell_word, rest zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   int          error_count    = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
   bit                         known [CELLS];
   int unsigned                cur_col = 0;
   int unsigned                cur_row = 0;
   logic [tcw_pkg::ATTR_W-1:0] text_attr = tcw_pkg::ATTR_RESET;
   tcw_pkg::result_type        pending_cursor_reports [$];

   text_console_writer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic tcw_pkg::result_type update_screen(input tcw_pkg::op_type op,
                                                         input logic [7:0] code,
                                                         input logic [10:0] addr);
      tcw_pkg::result_type r;
      int unsigned idx;
      r.cell_word = '0;
      case (op)
         tcw_pkg::OP_PUT: begin
            if (code == tcw_pkg::CHAR_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (code == tcw_pkg::CHAR_BACKSPACE) begin
               if (cur_col > 0) cur_col--;
               idx = cur_row * COLS + cur_col;
               screen[idx] = {text_attr, tcw_pkg::CHAR_BLANK};
               known[idx]  = 1'b1;
            end else begin
               idx = cur_row * COLS + cur_col;
               screen[idx] = {text_attr, code};
               known[idx]  = 1'b1;
               cur_col++;
            end
            if (cur_col >= COLS) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= ROWS) begin
               for (int i = 0; i < CELLS - COLS; i++) begin
                  screen[i] = screen[i + COLS];
                  known[i]  = known[i + COLS];
               end
               for (int i = CELLS - COLS; i < CELLS; i++) begin
                  screen[i] = {text_attr, tcw_pkg::CHAR_BLANK};
                  known[i]  = 1'b1;
               end
               cur_row = ROWS - 1;
            end
         end
         tcw_pkg::OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen[i] = {text_attr, tcw_pkg::CHAR_BLANK};
               known[i]  = 1'b1;
            end
            cur_col = 0;
            cur_row = 0;
         end
         tcw_pkg::OP_READ: begin
            if (addr < CELLS) r.cell_word = screen[addr];
         end
         default: ;
      endcase
      r.cursor_position = tcw_pkg::POS_W'(cur_row * COLS + cur_col);
      return r;
   endfunction

   function automatic logic [10:0] pick_read_address();
      logic [10:0] a;
      if ($urandom_range(99) < 12) return 11'($urandom_range(2047, CELLS));
      for (int tries = 0; tries < 64; tries++) begin
         if ($urandom_range(2) == 0) a = 11'(cur_row * COLS + $urandom_range(COLS - 1));
         else a = 11'($urandom_range(CELLS - 1));
         if (known[a]) return a;
      end
      return 11'(CELLS);
   endfunction

   always @(posedge clock) begin
      tcw_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cursor_reports.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, 0);
         end else begin
            want = pending_cursor_reports.pop_front();
            if (rsp_tdata[10:0] !== want.cursor_position)
               report_mismatch("cursor_position", rsp_tdata[10:0], want.cursor_position);
            if (rsp_tdata[26:11] !== want.cell_word)
               report_mismatch("cell_word", rsp_tdata[26:11], want.cell_word);
         end
      end
   end

   task automatic send_item(input tcw_pkg::op_type op, input logic [7:0] code,
                            input logic [10:0] addr);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, addr, code};
      do @(posedge clock); while (!req_tready);
      pending_cursor_reports.push_back(update_screen(op, code, addr));
      @(negedge clock);
   endtask

   task automatic wait_console_idle();
      req_tvalid <= 1'b0;
      while (pending_cursor_reports.size() != 0) @(negedge clock);
   endtask

   task automatic write_text_attribute(input logic [7:0] value);
      wait_console_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      text_attr = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_idle_op_after_reset();
      send_item(tcw_pkg::OP_NONE, 8'hFF, 11'h7FF);
      send_item(tcw_pkg::OP_PUT, 8'h41, 11'h000);
      send_item(tcw_pkg::OP_READ, 8'h00, 11'd0);
   endtask

   task automatic test_clear_and_bounds();
      send_item(tcw_pkg::OP_CLEAR, 8'h00, 11'd0);
      send_item(tcw_pkg::OP_READ, 8'h00, 11'd0);
      send_item(tcw_pkg::OP_READ, 8'hFF, 11'(CELLS - 1));
      send_item(tcw_pkg::OP_READ, 8'h00, 11'(CELLS));
      send_item(tcw_pkg::OP_READ, 8'h00, 11'h7FF);
   endtask

   task automatic test_character_extremes();
      send_item(tcw_pkg::OP_PUT, 8'h00, 11'h7FF);
      send_item(tcw_pkg::OP_PUT, 8'hFF, 11'h000);
      send_item(tcw_pkg::OP_READ, 8'h00, 11'd0);
      send_item(tcw_pkg::OP_READ, 8'h00, 11'd1);
   endtask

   task automatic test_backspace();
      send_item(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 11'd0);
      send_item(tcw_pkg::OP_READ, 8'h00, 11'd1);
      send_item(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 11'd0);
      send_item(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 11'd0);
      send_item(tcw_pkg::OP_READ, 8'h00, 11'd0);
   endtask

   task automatic test_newline();
      send_item(tcw_pkg::OP_PUT, 8'h78, 11'd0);
      send_item(tcw_pkg::OP_PUT, tcw_pkg::CHAR_NEWLINE, 11'd0);
      send_item(tcw_pkg::OP_READ, 8'h00, 11'd0);
   endtask

   task automatic test_console_traffic(input int item_count, input int idle_pct,
                                       input int stall_pct);
      int sent;
      int kind;
      int len;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_count) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            len = $urandom_range(60);
            repeat (len) send_item(tcw_pkg::OP_PUT, 8'($urandom_range(255)),
                                   11'($urandom_range(2047)));
            send_item(tcw_pkg::OP_PUT, tcw_pkg::CHAR_NEWLINE, 11'($urandom_range(2047)));
            sent += len + 1;
         end else if (kind < 70) begin
            len = $urandom_range(COLS, 2 * COLS + 10);
            repeat (len) send_item(tcw_pkg::OP_PUT, 8'($urandom_range(255)),
                                   11'($urandom_range(2047)));
            sent += len;
         end else if (kind < 80) begin
            len = $urandom_range(1, 8);
            repeat (len) send_item(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE,
                                   11'($urandom_range(2047)));
            sent += len;
         end else if (kind < 91) begin
            len = $urandom_range(1, 4);
            repeat (len) send_item(tcw_pkg::OP_READ, 8'($urandom_range(255)),
                                   pick_read_address());
            sent += len;
         end else if (kind < 95) begin
            len = $urandom_range(1, 6);
            repeat (len) send_item(tcw_pkg::OP_PUT, tcw_pkg::CHAR_NEWLINE,
                                   11'($urandom_range(2047)));
            sent += len;
         end else if (kind < 97) begin
            send_item(tcw_pkg::OP_NONE, 8'($urandom_range(255)), 11'($urandom_range(2047)));
            sent++;
         end else begin
            send_item(tcw_pkg::OP_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_idle_op_after_reset();
      test_clear_and_bounds();
      test_character_extremes();
      test_backspace();
      test_newline();
      write_text_attribute(8'h00);
      test_console_traffic(450, 0, 0);
      write_text_attribute(8'hFF);
      test_console_traffic(425, 65, 0);
      write_text_attribute(8'($urandom_range(254, 1)));
      test_console_traffic(425, 0, 65);
      write_text_attribute(tcw_pkg::ATTR_RESET);
      test_console_traffic(400, 6, 6);
      wait_console_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #600_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/tcw_pkg.sv
rtl/core/tcw_screen_ram.sv
rtl/core/tcw_engine.sv
rtl/core/text_console_writer.sv
sim/tb_text_console_writer.sv
